// File: hdl/qsm_pkg.sv
// qsm_pkg: shared types, sizes and the exponential table of the quantised softmax core
// no dependencies; imported by every module of the block
package qsm_pkg;

  // vector and field sizes
  localparam int CLASS_COUNT = 8;
  localparam int IDX_W       = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
  localparam int CNT_W       = $clog2(CLASS_COUNT + 2);
  localparam int SCORE_W     = 8;
  localparam int EXPO_W      = 5;
  localparam int CLASS_W     = 3;
  localparam int CONF_W      = 16;
  localparam int E_W         = 17;
  localparam int SUM_W       = 20;
  localparam int XQ_W        = 20;
  localparam int ACC_W       = 32;
  localparam int PROD_W      = 2 * ACC_W;
  localparam int K_W         = 5;
  localparam int DIV_STEPS   = 16;
  localparam int QUEUE_DEPTH = 2;

  // exponent register reset: -7
  localparam logic signed [EXPO_W-1:0] EXPO_RESET = -5'sd7;

  // one closed vector handed from front to back
  typedef struct packed {
    logic                                     err;
    logic signed [SCORE_W-1:0]                max;
    logic [CLASS_COUNT-1:0][SCORE_W-1:0]      scores;
  } job_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // back end sequencer
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_XQ,
    ST_BIT,
    ST_ACC,
    ST_ADD,
    ST_DIVSET,
    ST_DIV,
    ST_EMIT
  } back_state_t;

  // round(exp(-2^(k-16)) * 2^32) for bit k of the Q16 argument
  function automatic logic [ACC_W-1:0] exp_lut(input logic [K_W-1:0] k);
    logic [ACC_W-1:0] v;
    unique case (k)
      5'd0:    v = 32'd4294901760;
      5'd1:    v = 32'd4294836226;
      5'd2:    v = 32'd4294705160;
      5'd3:    v = 32'd4294443040;
      5'd4:    v = 32'd4293918848;
      5'd5:    v = 32'd4292870656;
      5'd6:    v = 32'd4290775039;
      5'd7:    v = 32'd4286586875;
      5'd8:    v = 32'd4278222805;
      5'd9:    v = 32'd4261543595;
      5'd10:   v = 32'd4228380000;
      5'd11:   v = 32'd4162825044;
      5'd12:   v = 32'd4034748382;
      5'd13:   v = 32'd3790295335;
      5'd14:   v = 32'd3344923893;
      5'd15:   v = 32'd2605029347;
      5'd16:   v = 32'd1580030169;
      5'd17:   v = 32'd581260615;
      5'd18:   v = 32'd78665070;
      5'd19:   v = 32'd1440801;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: hdl/qsm_front.sv
// qsm_front: takes scores, keeps the score store, count and running maximum
// depends on qsm_pkg; pushes one job word per closed vector into qsm_queue
module qsm_front
  import qsm_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  logic signed [SCORE_W-1:0] in_score,
  input  logic                      in_last,
  output logic                      push,
  output job_t                      push_job
);

  logic [CLASS_COUNT-1:0][SCORE_W-1:0] store_r, store_nxt;
  logic [CNT_W-1:0]                    count_r, count_nxt, count_inc;
  logic signed [SCORE_W-1:0]           max_r, max_nxt, max_upd;
  logic                                room;

  // merge the new score into store and maximum
  always_comb begin
    room      = (count_r < CNT_W'(CLASS_COUNT));
    store_nxt = store_r;
    max_upd   = max_r;
    count_inc = count_r;
    if (room) begin
      store_nxt[count_r[IDX_W-1:0]] = in_score;
      if (in_score > max_r) begin
        max_upd = in_score;
      end
    end
    if (count_r <= CNT_W'(CLASS_COUNT)) begin
      count_inc = count_r + CNT_W'(1);
    end
  end

  // job word and run clearing on the closing score, run update on every other score
  always_comb begin
    push            = accept && in_last;
    push_job.err    = (count_inc != CNT_W'(CLASS_COUNT));
    push_job.max    = max_upd;
    push_job.scores = store_nxt;
    count_nxt       = count_r;
    max_nxt         = max_r;
    if (accept) begin
      if (in_last) begin
        count_nxt = '0;
        max_nxt   = {1'b1, {(SCORE_W-1){1'b0}}};
      end else begin
        count_nxt = count_inc;
        max_nxt   = max_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      max_r   <= {1'b1, {(SCORE_W-1){1'b0}}};
    end else begin
      count_r <= count_nxt;
      max_r   <= max_nxt;
    end
  end

  // score store, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      store_r <= store_nxt;
    end
  end

endmodule

// File: hdl/qsm_queue.sv
// qsm_queue: short job queue between front and back
// depends on qsm_pkg for job_t, q_status_t and QUEUE_DEPTH
module qsm_queue
  import qsm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  job_t      push_job,
  input  logic      pop,
  output job_t      head,
  output q_status_t status
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t              slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] fill_r, fill_nxt;
  logic              do_push, do_pop;

  // occupancy and pointers
  always_comb begin
    status.full  = (fill_r == QCNT_W'(QUEUE_DEPTH));
    status.empty = (fill_r == '0);
    do_push      = push && !status.full;
    do_pop       = pop && !status.empty;
    head         = slot_r[rd_ptr_r];
    wr_ptr_nxt   = wr_ptr_r;
    rd_ptr_nxt   = rd_ptr_r;
    fill_nxt     = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // job slots, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// File: hdl/qsm_back.sv
// qsm_back: exponentials, saturating sum, bit-serial division and result words
// depends on qsm_pkg; takes jobs from qsm_queue, owns the exponent register
module qsm_back
  import qsm_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic signed [EXPO_W-1:0]  cfg_wr_data,
  input  q_status_t                 q_status,
  input  job_t                      head,
  output logic                      pop,
  output logic                      out_valid,
  output logic [CLASS_W-1:0]        out_class_index,
  output logic [CONF_W-1:0]         out_confidence,
  output logic                      out_status,
  output logic                      out_last_result
);

  back_state_t              state_r, state_nxt;
  job_t                     job_r, job_nxt;
  logic signed [EXPO_W-1:0] expo_r;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic [K_W-1:0]           k_r, k_nxt;
  logic [XQ_W-1:0]          xq_r, xq_nxt;
  logic                     over_r, over_nxt;
  logic                     one_r, one_nxt;
  logic [ACC_W-1:0]         acc_r, acc_nxt;
  logic [PROD_W-1:0]        prod_r, prod_nxt;
  logic [SUM_W-1:0]         sum_r, sum_nxt;
  logic [E_W-1:0]           exp_r [CLASS_COUNT];
  logic [SUM_W-1:0]         rem_r, rem_nxt;
  logic [CONF_W-1:0]        nlow_r, nlow_nxt;
  logic [CONF_W-1:0]        q_r, q_nxt;
  logic                     out_valid_nxt, out_status_nxt, out_last_nxt;
  logic [CLASS_W-1:0]       out_class_nxt;
  logic [CONF_W-1:0]        out_conf_nxt;

  // datapath helpers
  logic                     last_class, last_bit, last_step;
  logic [SCORE_W:0]         diff_w;
  logic [XQ_W+SCORE_W+ACC_W-1:0] wide;
  logic [EXPO_W-1:0]        shift;
  logic [ACC_W-1:0]         lut_val;
  logic [PROD_W:0]          rnd;
  logic [E_W-1:0]           e_new, e_sel;
  logic [SUM_W:0]           sum_add;
  logic [E_W+CONF_W-1:0]    numer;
  logic [SUM_W:0]           trial;
  logic                     qbit;

  assign last_class = (idx_r == IDX_W'(CLASS_COUNT - 1));
  assign last_bit   = (k_r == K_W'(XQ_W - 1));
  assign last_step  = (k_r == K_W'(DIV_STEPS - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_status.empty) begin
          state_nxt = head.err ? ST_ERR : ST_XQ;
        end
      end
      ST_ERR:    state_nxt = ST_IDLE;
      ST_XQ:     state_nxt = ST_BIT;
      ST_BIT: begin
        if (over_r) begin
          state_nxt = ST_ADD;
        end else if (xq_r[k_r] && !one_r) begin
          state_nxt = ST_ACC;
        end else if (last_bit) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ACC:    state_nxt = last_bit ? ST_ADD : ST_BIT;
      ST_ADD:    state_nxt = last_class ? ST_DIVSET : ST_XQ;
      ST_DIVSET: state_nxt = ST_DIV;
      ST_DIV:    state_nxt = last_step ? ST_EMIT : ST_DIV;
      ST_EMIT:   state_nxt = last_class ? ST_IDLE : ST_DIVSET;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    job_nxt        = job_r;
    idx_nxt        = idx_r;
    k_nxt          = k_r;
    xq_nxt         = xq_r;
    over_nxt       = over_r;
    one_nxt        = one_r;
    acc_nxt        = acc_r;
    prod_nxt       = prod_r;
    sum_nxt        = sum_r;
    rem_nxt        = rem_r;
    nlow_nxt       = nlow_r;
    q_nxt          = q_r;
    out_valid_nxt  = 1'b0;
    out_class_nxt  = '0;
    out_conf_nxt   = '0;
    out_status_nxt = 1'b0;
    out_last_nxt   = 1'b0;
    pop            = 1'b0;

    // argument of the exponential in Q16
    diff_w  = {job_r.max[SCORE_W-1], job_r.max} - {job_r.scores[idx_r][SCORE_W-1],
                                                   job_r.scores[idx_r]};
    shift   = {~expo_r[EXPO_W-1], expo_r[EXPO_W-2:0]};
    wide    = (XQ_W+SCORE_W+ACC_W)'(diff_w[SCORE_W-1:0]) << shift;
    lut_val = exp_lut(k_r);
    rnd     = (PROD_W+1)'(prod_r) + (PROD_W+1)'(64'h8000_0000);
    e_new   = over_r ? '0 : (one_r ? E_W'(17'h10000) : E_W'(acc_r[ACC_W-1:ACC_W-CONF_W]));
    sum_add = (SUM_W+1)'(sum_r) + (SUM_W+1)'(e_new);
    e_sel   = exp_r[idx_r];
    numer   = {e_sel, {CONF_W{1'b0}}} - (E_W+CONF_W)'(e_sel);
    trial   = {rem_r, nlow_r[CONF_W-1]};
    qbit    = (trial >= (SUM_W+1)'(sum_r));

    unique case (state_r)
      ST_IDLE: begin
        if (!q_status.empty) begin
          pop     = 1'b1;
          job_nxt = head;
          idx_nxt = '0;
          sum_nxt = '0;
        end
      end
      ST_ERR: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = 1'b1;
        out_last_nxt   = 1'b1;
      end
      ST_XQ: begin
        xq_nxt   = wide[XQ_W-1:0];
        over_nxt = |wide[XQ_W+SCORE_W+ACC_W-1:XQ_W];
        one_nxt  = 1'b1;
        k_nxt    = '0;
      end
      ST_BIT: begin
        if (!over_r) begin
          if (xq_r[k_r] && one_r) begin
            // first factor: 1.0 times the table entry is the entry itself
            acc_nxt = lut_val;
            one_nxt = 1'b0;
            k_nxt   = k_r + K_W'(1);
          end else if (xq_r[k_r]) begin
            prod_nxt = PROD_W'(acc_r) * PROD_W'(lut_val);
          end else begin
            k_nxt = k_r + K_W'(1);
          end
        end
      end
      ST_ACC: begin
        acc_nxt = rnd[PROD_W-1:ACC_W];
        k_nxt   = k_r + K_W'(1);
      end
      ST_ADD: begin
        sum_nxt = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
        idx_nxt = last_class ? '0 : idx_r + IDX_W'(1);
      end
      ST_DIVSET: begin
        rem_nxt  = SUM_W'(numer[E_W+CONF_W-1:CONF_W]);
        nlow_nxt = numer[CONF_W-1:0];
        q_nxt    = '0;
        k_nxt    = '0;
      end
      ST_DIV: begin
        rem_nxt  = qbit ? SUM_W'(trial - (SUM_W+1)'(sum_r)) : trial[SUM_W-1:0];
        q_nxt    = {q_r[CONF_W-2:0], qbit};
        nlow_nxt = {nlow_r[CONF_W-2:0], 1'b0};
        k_nxt    = k_r + K_W'(1);
      end
      ST_EMIT: begin
        out_valid_nxt = 1'b1;
        out_class_nxt = CLASS_W'(idx_r);
        out_conf_nxt  = q_r;
        out_last_nxt  = last_class;
        idx_nxt       = last_class ? '0 : idx_r + IDX_W'(1);
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_valid <= 1'b0;
      expo_r    <= EXPO_RESET;
    end else begin
      state_r   <= state_nxt;
      out_valid <= out_valid_nxt;
      if (cfg_wr_en) begin
        expo_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    job_r           <= job_nxt;
    idx_r           <= idx_nxt;
    k_r             <= k_nxt;
    xq_r            <= xq_nxt;
    over_r          <= over_nxt;
    one_r           <= one_nxt;
    acc_r           <= acc_nxt;
    prod_r          <= prod_nxt;
    sum_r           <= sum_nxt;
    rem_r           <= rem_nxt;
    nlow_r          <= nlow_nxt;
    q_r             <= q_nxt;
    out_class_index <= out_class_nxt;
    out_confidence  <= out_conf_nxt;
    out_status      <= out_status_nxt;
    out_last_result <= out_last_nxt;
    if (state_r == ST_ADD) begin
      exp_r[idx_r] <= e_new;
    end
  end

endmodule

// File: hdl/quantized_softmax_core.sv
// quantized_softmax_core: top level of the quantised softmax block
// depends on qsm_pkg, qsm_front, qsm_queue and qsm_back
//
// Scores enter one word per cycle while busy is low (start high takes the word);
// in_last closes a vector. A closed vector of exactly CLASS_COUNT scores gives
// CLASS_COUNT result words in class order, each shown for one cycle on out_valid;
// any other length gives one word with out_status set. Results cannot be held off.
// The front keeps taking scores while fewer than QUEUE_DEPTH closed vectors wait; busy
// rises only when that queue is full. Per vector the back first takes the job, then for
// each class forms the argument and steps through its bits, multiplying in the table
// entry for every set bit after the first, or goes straight to the sum when the argument
// is out of range; then for each class it runs the bit-serial division and emits the
// result word, using the shared 32x32 multiplier and the one-bit-per-cycle divider.
// An error vector skips all of this and gives its error word.
module quantized_softmax_core
  import qsm_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [SCORE_W-1:0] in_score,
  input  logic                      in_last,
  input  logic                      cfg_wr_en,
  input  logic signed [EXPO_W-1:0]  cfg_wr_data,
  output logic                      out_valid,
  output logic [CLASS_W-1:0]        out_class_index,
  output logic [CONF_W-1:0]         out_confidence,
  output logic                      out_status,
  output logic                      out_last_result
);

  q_status_t q_status;
  job_t      push_job, head;
  logic      push, pop, accept;

  // front takes a word when start is high and the queue has room
  assign busy   = q_status.full;
  assign accept = start && !busy;

  qsm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_score (in_score),
    .in_last  (in_last),
    .push     (push),
    .push_job (push_job)
  );

  qsm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  qsm_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .q_status        (q_status),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_class_index (out_class_index),
    .out_confidence  (out_confidence),
    .out_status      (out_status),
    .out_last_result (out_last_result)
  );

endmodule

// File: hdl/qsm_checker.sv
// qsm_checker: port-level checks on the quantised softmax core, bound to the top
// depends on qsm_pkg for field widths and CLASS_COUNT
module qsm_checker
  import qsm_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      busy,
  input logic                      out_valid,
  input logic [CLASS_W-1:0]        out_class_index,
  input logic [CONF_W-1:0]         out_confidence,
  input logic                      out_status,
  input logic                      out_last_result
);

  // queue is empty straight after reset
  a_idle_after_reset: assert property (@(posedge clk) !rst_n |=> !busy)
    else $error("busy high after reset");

  // result words never come in adjacent cycles
  a_word_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result words back to back");

  // an error word is the single last word, class 0, confidence 0
  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |->
      (out_last_result && out_class_index == '0 && out_confidence == '0))
    else $error("malformed error word");

  // last flag sits on the final class only
  a_last_class: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_status) |->
      (out_last_result == (out_class_index == CLASS_W'(CLASS_COUNT - 1))))
    else $error("last flag on wrong class");

  // class order: a word that is not last is not followed at once by another word, nor then by class 0
  a_class_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_status && !out_last_result) |=>
      (!out_valid ##1 (!out_valid || out_class_index != '0)))
    else $error("class order broken");

endmodule

bind quantized_softmax_core qsm_checker u_qsm_checker (.*);
